// ===== rtl/series_mean_dark_subtract_assert.svh =====
// ----------------------------------------------------------------------------
// series_mean_dark_subtract assertion macros
// Concurrent checks, clocked on clk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef SERIES_MEAN_DARK_SUBTRACT_ASSERT_SVH
`define SERIES_MEAN_DARK_SUBTRACT_ASSERT_SVH

`ifndef ASSERT_OFF
`define SMDS_ASSERT_IMPLIES(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define SMDS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define SMDS_ASSERT_IMPLIES(lbl, ante, cons, msg)
`define SMDS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== rtl/smds_pkg.sv =====
// ----------------------------------------------------------------------------
// smds_pkg
// Constants shared by the frame averaging block.
// ----------------------------------------------------------------------------
package smds_pkg;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 12;
	localparam int PC_REG_W   = 12;
	localparam int FC_REG_W   = 9;

	localparam logic [CFG_IDX_W-1:0] REG_PIXEL_COUNT   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAMES        = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DARK_SUBTRACT = 2'd2;

	localparam logic [PC_REG_W-1:0] PC_RESET = 12'd2048;
	localparam logic [FC_REG_W-1:0] FC_RESET = 9'd1;

	localparam int IN_W       = 16;
	localparam int PIX_OUT_W  = 11;
	localparam int MEAN_W     = 24;
	localparam int FRAC_BITS  = 8;

	localparam logic [MEAN_W-1:0] MEAN_MAX  = 24'hFFFFFF;
	localparam logic [MEAN_W-1:0] ONE_FIXED = 24'd256;

endpackage

// ===== rtl/smds_acc_mem.sv =====
// ----------------------------------------------------------------------------
// smds_acc_mem
// Per-pixel sum store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module smds_acc_mem #(
	parameter int DEPTH = 2048,
	parameter int WIDTH = 25
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/smds_divider.sv =====
// ----------------------------------------------------------------------------
// smds_divider
// Restoring divider, one quotient bit per cycle; done pulses once.
// ----------------------------------------------------------------------------
module smds_divider #(
	parameter int NUM_W = 32,
	parameter int DEN_W = 9
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  logic [NUM_W-1:0] dividend,
	input  logic [DEN_W-1:0] divisor,
	output logic             done,
	output logic [NUM_W-1:0] quotient
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] num_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W-1:0] rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic             run_q;
	logic             done_q;

	logic [DEN_W:0]   rem_sh;
	logic [DEN_W:0]   rem_sub;
	logic             ge;

	assign rem_sh  = {rem_q, num_q[NUM_W-1]};
	assign rem_sub = rem_sh - {1'b0, den_q};
	assign ge      = (rem_sh >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (load) begin
				run_q <= 1'b1;
				cnt_q <= CNT_W'(NUM_W);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			num_q <= dividend;
			den_q <= divisor;
			rem_q <= '0;
		end else if (run_q) begin
			rem_q <= ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
			num_q <= {num_q[NUM_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = num_q;

endmodule

// ===== rtl/series_mean_dark_subtract.sv =====
// ----------------------------------------------------------------------------
// series_mean_dark_subtract
// Per-pixel mean of a frame series with optional dark subtraction.
// Outside the last frame a word passes through accept, sum read and accumulate.
// On the last frame of a series the word then waits for the divider, which yields
// one quotient bit per cycle and then pulses done.
// A negative sum skips the divider. The result is strobed in the first cycle
// with busy low and cannot be held off.
// Reset clears the config registers and positions; the sum store holds no reset state.
// ----------------------------------------------------------------------------
`include "series_mean_dark_subtract_assert.svh"

module series_mean_dark_subtract #(
	parameter int MAX_PIXELS  = 2048,
	parameter int MAX_FRAMES  = 256,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [smds_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [smds_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                start,
	output logic                                busy,
	input  logic [smds_pkg::IN_W-1:0]           signal_sample,
	input  logic [smds_pkg::IN_W-1:0]           dark_sample,
	output logic                                result_strobe,
	output logic [smds_pkg::PIX_OUT_W-1:0]      pixel_index,
	output logic [smds_pkg::MEAN_W-1:0]         mean_value,
	output logic                                last_pixel
);

	localparam int PIX_W  = $clog2(MAX_PIXELS);
	localparam int FR_W   = $clog2(MAX_FRAMES);
	localparam int FC_W   = $clog2(MAX_FRAMES + 1);
	localparam int SUM_W  = SAMPLE_BITS + 1 + $clog2(MAX_FRAMES);
	localparam int NUM_W  = SUM_W - 1 + smds_pkg::FRAC_BITS;
	localparam int QW     = (NUM_W > smds_pkg::MEAN_W) ? NUM_W : smds_pkg::MEAN_W;
	localparam int XW     = (SAMPLE_BITS > smds_pkg::IN_W) ? SAMPLE_BITS : smds_pkg::IN_W;
	localparam int PW     = (PIX_W > smds_pkg::PIX_OUT_W) ? PIX_W : smds_pkg::PIX_OUT_W;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RD   = 2'd1;
	localparam logic [1:0] ST_ACC  = 2'd2;
	localparam logic [1:0] ST_DIV  = 2'd3;

	logic [1:0]                     state_q;
	logic [smds_pkg::PC_REG_W-1:0]  pc_reg_q;
	logic [smds_pkg::FC_REG_W-1:0]  fc_reg_q;
	logic                           dark_q;
	logic [PIX_W-1:0]               pix_pos_q;
	logic [FR_W-1:0]                fr_pos_q;

	logic [PIX_W-1:0]               pix_q;
	logic [SUM_W-1:0]               diff_q;
	logic                           first_q;
	logic                           lastfr_q;
	logic                           lastpix_q;

	logic                           strobe_q;
	logic [smds_pkg::PIX_OUT_W-1:0] pix_out_q;
	logic [smds_pkg::MEAN_W-1:0]    mean_q;
	logic                           last_q;

	logic [31:0]                    pc32;
	logic [31:0]                    fc32;
	logic [PIX_W-1:0]               pc_last;
	logic [FR_W-1:0]                fc_last;
	logic [FC_W-1:0]                fc_div;
	logic [PIX_W-1:0]               pix_eff;
	logic [FR_W-1:0]                fr_eff;
	logic [XW-1:0]                  sig_x;
	logic [XW-1:0]                  dark_x;
	logic [SUM_W-1:0]               diff_in;
	logic                           accept;

	logic [SUM_W-1:0]               rd_sum;
	logic [SUM_W-1:0]               sum_new;
	logic                           mem_we;
	logic                           div_load;
	logic                           div_done;
	logic [NUM_W-1:0]               quotient;
	logic [QW-1:0]                  q_ext;
	logic [PW-1:0]                  pix_ext;

	// count registers: zero reads as one, above the maximum saturates
	always_comb begin
		if (pc_reg_q == '0) begin
			pc32 = 32'd1;
		end else if (32'(pc_reg_q) > 32'(MAX_PIXELS)) begin
			pc32 = 32'(MAX_PIXELS);
		end else begin
			pc32 = 32'(pc_reg_q);
		end
		if (fc_reg_q == '0) begin
			fc32 = 32'd1;
		end else if (32'(fc_reg_q) > 32'(MAX_FRAMES)) begin
			fc32 = 32'(MAX_FRAMES);
		end else begin
			fc32 = 32'(fc_reg_q);
		end
	end

	assign pc_last = PIX_W'(pc32 - 32'd1);
	assign fc_last = FR_W'(fc32 - 32'd1);
	assign fc_div  = FC_W'(fc32);
	assign pix_eff = (pix_pos_q > pc_last) ? '0 : pix_pos_q;
	assign fr_eff  = (fr_pos_q > fc_last) ? '0 : fr_pos_q;

	assign sig_x   = XW'(signal_sample);
	assign dark_x  = XW'(dark_sample);
	assign diff_in = SUM_W'(sig_x[SAMPLE_BITS-1:0])
		- (dark_q ? SUM_W'(dark_x[SAMPLE_BITS-1:0]) : '0);

	assign accept  = start && (state_q == ST_IDLE);
	assign busy    = (state_q != ST_IDLE);

	assign sum_new  = first_q ? diff_q : (rd_sum + diff_q);
	assign mem_we   = (state_q == ST_ACC);
	assign div_load = (state_q == ST_ACC) && lastfr_q && !sum_new[SUM_W-1];
	assign q_ext    = QW'(quotient);
	assign pix_ext  = PW'(pix_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			pc_reg_q  <= smds_pkg::PC_RESET;
			fc_reg_q  <= smds_pkg::FC_RESET;
			dark_q    <= 1'b0;
			pix_pos_q <= '0;
			fr_pos_q  <= '0;
			strobe_q  <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			if (cfg_we) begin
				unique case (cfg_index)
					smds_pkg::REG_PIXEL_COUNT: begin
						pc_reg_q  <= cfg_data[smds_pkg::PC_REG_W-1:0];
						pix_pos_q <= '0;
						fr_pos_q  <= '0;
					end
					smds_pkg::REG_FRAMES: begin
						fc_reg_q  <= cfg_data[smds_pkg::FC_REG_W-1:0];
						pix_pos_q <= '0;
						fr_pos_q  <= '0;
					end
					smds_pkg::REG_DARK_SUBTRACT: begin
						dark_q <= cfg_data[0];
					end
					default: begin
					end
				endcase
			end
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_RD;
						if (pix_eff == pc_last) begin
							pix_pos_q <= '0;
							fr_pos_q  <= (fr_eff == fc_last) ? '0 : fr_eff + 1'b1;
						end else begin
							pix_pos_q <= pix_eff + 1'b1;
							fr_pos_q  <= fr_eff;
						end
					end
				end
				ST_RD: begin
					state_q <= ST_ACC;
				end
				ST_ACC: begin
					if (lastfr_q && !sum_new[SUM_W-1]) begin
						state_q <= ST_DIV;
					end else begin
						state_q  <= ST_IDLE;
						strobe_q <= lastfr_q;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						state_q  <= ST_IDLE;
						strobe_q <= 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// word payload and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			pix_q     <= pix_eff;
			diff_q    <= diff_in;
			first_q   <= (fr_eff == '0);
			lastfr_q  <= (fr_eff == fc_last);
			lastpix_q <= (pix_eff == pc_last);
		end
		if (state_q == ST_ACC) begin
			pix_out_q <= pix_ext[smds_pkg::PIX_OUT_W-1:0];
			last_q    <= lastpix_q;
			mean_q    <= smds_pkg::ONE_FIXED;
		end
		if (div_done) begin
			mean_q <= (q_ext > QW'(smds_pkg::MEAN_MAX)) ? smds_pkg::MEAN_MAX
				: q_ext[smds_pkg::MEAN_W-1:0];
		end
	end

	smds_acc_mem #(
		.DEPTH (MAX_PIXELS),
		.WIDTH (SUM_W)
	) u_acc_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (pix_q),
		.wdata (sum_new),
		.raddr (pix_q),
		.rdata (rd_sum)
	);

	smds_divider #(
		.NUM_W (NUM_W),
		.DEN_W (FC_W)
	) u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (div_load),
		.dividend ({sum_new[SUM_W-2:0], {smds_pkg::FRAC_BITS{1'b0}}}),
		.divisor  (fc_div),
		.done     (div_done),
		.quotient (quotient)
	);

	assign result_strobe = strobe_q;
	assign pixel_index   = pix_out_q;
	assign mean_value    = mean_q;
	assign last_pixel    = last_q;

	`SMDS_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted word did not raise busy")
	`SMDS_ASSERT_NEXT(a_strobe_single, result_strobe, !result_strobe, "back-to-back result strobes")
	`SMDS_ASSERT_IMPLIES(a_div_in_state, div_done, state_q == ST_DIV, "divider finished outside DIV")
	`SMDS_ASSERT_IMPLIES(a_strobe_idle, result_strobe, state_q == ST_IDLE, "result strobed while busy")

endmodule
